/* src/ivm_pkg.sv */
// ----------------------------------------------------------------------------
// ivm_pkg
// Shared types and constants for the interval value map.
// ----------------------------------------------------------------------------
package ivm_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 8;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_PAD,
    S_DUMP
  } state_e;

  // Controls broadcast to every table cell.
  typedef struct packed {
    logic rot;     // rotate the live table one cell toward the head
    logic push;    // shift the work row one cell toward the head
    logic commit;  // copy the work row over the live table
  } cell_ctrl_t;

  // Status of the merge unit toward the sequencer.
  typedef struct packed {
    logic rot;
    logic push;
    logic done;
  } merge_st_t;

endpackage

/* src/interval_value_map.sv */
// ----------------------------------------------------------------------------
// interval_value_map
// Sorted breakpoint table held in a ring of cells, updated by range assigns.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel (in_valid_i / in_stall_o) assigns
// new_value to keys [range_begin, range_end). The block then sends the whole
// table on the output channel (out_valid_o / out_stall_i), one transfer per
// entry, last_o on the final one; an empty table gives one transfer with
// entry_valid_o low. status_o is the same on every transfer of a run.
// The user must write the default value over the cfg_valid_i / cfg_ready_o
// channel only while the block is idle; the block does not enforce it.
// For each item, the merge pass walks the ring once and emits the two range
// ends; the new entries are then shifted to the head and committed; the dump
// rotates the ring home, one entry per cycle while the output is free. The
// block is busy from an item's transfer until its dump is done and takes no
// new input before then; an ignored range goes straight to the dump.
// A stall on the output holds the dump without losing any entry.
// Reset empties the table and sets the default value to zero.
// ----------------------------------------------------------------------------
module interval_value_map #(
  parameter int unsigned TABLE_ENTRIES = ivm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] range_begin_i,
  input  logic signed [31:0] range_end_i,
  input  logic [7:0]         new_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic               entry_valid_o,
  output logic signed [31:0] entry_key_o,
  output logic [7:0]         entry_value_o,
  output logic               last_o
);
  import ivm_pkg::*;

  localparam int unsigned N  = TABLE_ENTRIES;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned KW = $clog2(N + 3);
  localparam logic [CW-1:0] NUM_C = CW'(N);
  localparam logic [KW-1:0] NUM_K = KW'(N);

  state_e state_q, state_d;
  status_e status_q, status_d;
  logic [7:0] dflt_q;
  logic signed [31:0] b_q, e_q;
  logic [7:0] v_q;
  logic [CW-1:0] cnt_q, cnt_d, dump_q, dump_d;
  logic [KW-1:0] pad_q, pad_d;

  cell_ctrl_t ctrl;
  merge_st_t  mst;
  logic merge_clr, merge_en, in_xfer, out_free, out_load;
  logic signed [31:0] push_key;
  logic [7:0] push_val;
  logic [KW-1:0] kept;

  logic signed [31:0] tkey [N];
  logic [7:0]         tval [N];
  logic signed [31:0] wkey [N];
  logic [7:0]         wval [N];

  logic out_valid_q, ld_evalid, ld_last;
  status_e out_status_q;
  logic out_evalid_q, out_last_q;
  logic signed [31:0] out_key_q;
  logic [7:0] out_val_q;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free  = !out_valid_q || !out_stall_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned NX = (g + 1) % N;
    logic signed [31:0] wk_in;
    logic [7:0]         wv_in;
    if (g == N - 1) begin : g_tail
      assign wk_in = (state_q == S_BUILD) ? push_key : '0;
      assign wv_in = (state_q == S_BUILD) ? push_val : '0;
    end else begin : g_mid
      assign wk_in = wkey[NX];
      assign wv_in = wval[NX];
    end
    ivm_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .tbl_key_i (tkey[NX]),
      .tbl_val_i (tval[NX]),
      .wrk_key_i (wk_in),
      .wrk_val_i (wv_in),
      .tbl_key_o (tkey[g]),
      .tbl_val_o (tval[g]),
      .wrk_key_o (wkey[g]),
      .wrk_val_o (wval[g])
    );
  end

  ivm_merge #(.TABLE_ENTRIES(N)) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (merge_clr),
    .en_i       (merge_en),
    .head_key_i (tkey[0]),
    .head_val_i (tval[0]),
    .cnt_i      (cnt_q),
    .b_i        (b_q),
    .e_i        (e_q),
    .v_i        (v_q),
    .dflt_i     (dflt_q),
    .st_o       (mst),
    .push_key_o (push_key),
    .push_val_o (push_val),
    .kept_o     (kept)
  );

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    cnt_d     = cnt_q;
    dump_d    = dump_q;
    pad_d     = pad_q;
    merge_clr = 1'b0;
    merge_en  = 1'b0;
    ctrl      = '0;
    out_load  = 1'b0;
    ld_evalid = 1'b0;
    ld_last   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          dump_d = '0;
          if (range_begin_i >= range_end_i) begin
            status_d = ST_EMPTY;
            state_d  = S_DUMP;
          end else begin
            merge_clr = 1'b1;
            state_d   = S_BUILD;
          end
        end
      end
      S_BUILD: begin
        merge_en  = 1'b1;
        ctrl.rot  = mst.rot;
        ctrl.push = mst.push;
        if (mst.done) begin
          if (kept > NUM_K) begin
            status_d = ST_OVERFLOW;
            state_d  = S_DUMP;
          end else begin
            pad_d   = kept;
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        // Shift the new entries down until the first one sits at the head.
        if (pad_q == NUM_K) begin
          ctrl.commit = 1'b1;
          cnt_d       = kept[CW-1:0];
          status_d    = ST_APPLIED;
          state_d     = S_DUMP;
        end else begin
          ctrl.push = 1'b1;
          pad_d     = pad_q + 1'b1;
        end
      end
      S_DUMP: begin
        if (cnt_q == '0) begin
          if (out_free) begin
            out_load = 1'b1;
            ld_last  = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (dump_q < cnt_q) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_evalid = 1'b1;
            ld_last   = (dump_q + 1'b1 == cnt_q);
            ctrl.rot  = 1'b1;
            dump_d    = dump_q + 1'b1;
          end
        end else if (dump_q != NUM_C) begin
          ctrl.rot = 1'b1;
          dump_d   = dump_q + 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_APPLIED;
      cnt_q       <= '0;
      dump_q      <= '0;
      pad_q       <= '0;
      dflt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      dump_q   <= dump_d;
      pad_q    <= pad_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dflt_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      b_q <= range_begin_i;
      e_q <= range_end_i;
      v_q <= new_value_i;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_evalid_q <= ld_evalid;
      out_key_q    <= ld_evalid ? tkey[0] : '0;
      out_val_q    <= ld_evalid ? tval[0] : '0;
      out_last_q   <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_valid_o = out_evalid_q;
  assign entry_key_o   = out_key_q;
  assign entry_value_o = out_val_q;
  assign last_o        = out_last_q;

endmodule

/* src/ivm_cell.sv */
// ----------------------------------------------------------------------------
// ivm_cell
// One table slot: a live entry that rotates around the ring and a work entry
// that shifts in from the tail while a new table is built.
// ----------------------------------------------------------------------------
module ivm_cell (
  input  logic                          clk_i,
  input  ivm_pkg::cell_ctrl_t           ctrl_i,
  input  logic signed [31:0]            tbl_key_i,
  input  logic [7:0]                    tbl_val_i,
  input  logic signed [31:0]            wrk_key_i,
  input  logic [7:0]                    wrk_val_i,
  output logic signed [31:0]            tbl_key_o,
  output logic [7:0]                    tbl_val_o,
  output logic signed [31:0]            wrk_key_o,
  output logic [7:0]                    wrk_val_o
);
  import ivm_pkg::*;

  logic signed [31:0] tbl_key_q, wrk_key_q;
  logic [7:0]         tbl_val_q, wrk_val_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      tbl_key_q <= wrk_key_q;
      tbl_val_q <= wrk_val_q;
    end else if (ctrl_i.rot) begin
      tbl_key_q <= tbl_key_i;
      tbl_val_q <= tbl_val_i;
    end
    if (ctrl_i.push) begin
      wrk_key_q <= wrk_key_i;
      wrk_val_q <= wrk_val_i;
    end
  end

  assign tbl_key_o = tbl_key_q;
  assign tbl_val_o = tbl_val_q;
  assign wrk_key_o = wrk_key_q;
  assign wrk_val_o = wrk_val_q;

endmodule

/* src/ivm_merge.sv */
// ----------------------------------------------------------------------------
// ivm_merge
// Merges the old table, read in order at the ring head, with the new range
// and drops every entry whose value equals the one before it.
// ----------------------------------------------------------------------------
module ivm_merge #(
  parameter int unsigned TABLE_ENTRIES = ivm_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1),
  localparam int unsigned KW = $clog2(TABLE_ENTRIES + 3)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 en_i,
  input  logic signed [31:0]   head_key_i,
  input  logic [7:0]           head_val_i,
  input  logic [CW-1:0]        cnt_i,
  input  logic signed [31:0]   b_i,
  input  logic signed [31:0]   e_i,
  input  logic [7:0]           v_i,
  input  logic [7:0]           dflt_i,
  output ivm_pkg::merge_st_t   st_o,
  output logic signed [31:0]   push_key_o,
  output logic [7:0]           push_val_o,
  output logic [KW-1:0]        kept_o
);
  import ivm_pkg::*;

  localparam logic [CW-1:0] NUM = CW'(TABLE_ENTRIES);

  logic          b_done_q, b_done_d, e_done_q, e_done_d;
  logic [CW-1:0] i_q, i_d, rot_q, rot_d;
  logic [7:0]    tail_q, tail_d, prev_q, prev_d;
  logic [KW-1:0] kept_q, kept_d;
  logic          emit, rot, push, at_end;
  logic signed [31:0] ek;
  logic [7:0]    ev;

  always_comb begin
    b_done_d = b_done_q;
    e_done_d = e_done_q;
    i_d      = i_q;
    rot_d    = rot_q;
    tail_d   = tail_q;
    prev_d   = prev_q;
    kept_d   = kept_q;
    emit     = 1'b0;
    rot      = 1'b0;
    ek       = head_key_i;
    ev       = head_val_i;
    at_end   = (i_q == cnt_i);
    if (en_i) begin
      if (!b_done_q && (at_end || head_key_i >= b_i)) begin
        emit     = 1'b1;
        ek       = b_i;
        ev       = v_i;
        b_done_d = 1'b1;
      end else if (!e_done_q && (at_end || head_key_i > e_i)) begin
        emit     = 1'b1;
        ek       = e_i;
        ev       = tail_q;
        e_done_d = 1'b1;
      end else if (rot_q != NUM) begin
        rot   = 1'b1;
        rot_d = rot_q + 1'b1;
        if (!at_end) begin
          i_d = i_q + 1'b1;
          // Entries inside [begin, end] are overwritten by the new range.
          emit = (head_key_i < b_i) || (head_key_i > e_i);
          if (head_key_i <= e_i) begin
            tail_d = head_val_i;
          end
        end
      end
    end
    push = emit && (ev != prev_q);
    if (push) begin
      prev_d = ev;
      kept_d = kept_q + 1'b1;
    end
    if (clr_i) begin
      b_done_d = 1'b0;
      e_done_d = 1'b0;
      i_d      = '0;
      rot_d    = '0;
      kept_d   = '0;
      tail_d   = dflt_i;
      prev_d   = dflt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_done_q <= 1'b0;
      e_done_q <= 1'b0;
      i_q      <= '0;
      rot_q    <= '0;
      kept_q   <= '0;
      tail_q   <= '0;
      prev_q   <= '0;
    end else begin
      b_done_q <= b_done_d;
      e_done_q <= e_done_d;
      i_q      <= i_d;
      rot_q    <= rot_d;
      kept_q   <= kept_d;
      tail_q   <= tail_d;
      prev_q   <= prev_d;
    end
  end

  assign st_o.rot    = rot;
  assign st_o.push   = push;
  assign st_o.done   = b_done_q && e_done_q && (rot_q == NUM);
  assign push_key_o  = ek;
  assign push_val_o  = ev;
  assign kept_o      = kept_q;

endmodule

/* src/ivm_checker.sv */
// ----------------------------------------------------------------------------
// ivm_checker
// Port-level checks for the interval value map, bound to the top level.
// ----------------------------------------------------------------------------
module ivm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [7:0]         cfg_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [31:0] range_begin_i,
  input logic signed [31:0] range_end_i,
  input logic [7:0]         new_value_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic               entry_valid_o,
  input logic signed [31:0] entry_key_o,
  input logic [7:0]         entry_value_o,
  input logic               last_o
);
  import ivm_pkg::*;

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_key_o)
      && $stable(entry_value_o) && $stable(last_o) && $stable(status_o))
    else $error("stalled result changed");

  // An accepted assign keeps the block busy for at least the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // An empty table is reported by a single closing transfer.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_o)
    else $error("empty-table result is not last");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

endmodule

bind interval_value_map ivm_checker u_ivm_checker (.*);
